[hw/rtl/spi_master_crc8_frame_unit_defines.svh]
// ----------------------------------------------------------------------------
// SPI master CRC-8 frame unit: assertion macros
// Shared property macros for the checker of the frame unit.
// ----------------------------------------------------------------------------
`ifndef SPI_MASTER_CRC8_FRAME_UNIT_DEFINES_SVH
`define SPI_MASTER_CRC8_FRAME_UNIT_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SMCF_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("frame unit assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define SMCF_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("frame unit assertion failed");

`endif

[hw/rtl/smcf_pkg.sv]
// ----------------------------------------------------------------------------
// SPI master CRC-8 frame package
// Types, constants and the CRC-8 bit table shared by the frame unit.
// ----------------------------------------------------------------------------
`default_nettype none

package smcf_pkg;

  localparam int unsigned CmdBits   = 24;
  localparam int unsigned CmdBytes  = 3;
  localparam int unsigned CrcBits   = 8;
  localparam int unsigned FrameBits = 32;
  localparam int unsigned PosBits   = 5;

  localparam logic [CrcBits-1:0]   CrcPoly    = 8'h1D;
  localparam logic [PosBits-1:0]   PosFirst   = 5'd31;
  localparam logic [PosBits-1:0]   PosLast    = 5'd0;

  // Action codes of an input item.
  localparam logic ActLoad  = 1'b0;
  localparam logic ActShift = 1'b1;

  typedef struct packed {
    logic               action;
    logic [CmdBits-1:0] command;
    logic               miso_bit;
  } item_t;

  typedef struct packed {
    logic                 mosi_bit;
    logic [FrameBits-1:0] received_word;
    logic                 frame_done;
  } result_t;

  // The CRC has zero initial value and no final xor, so it is linear in the
  // command bits: each set bit contributes the CRC of that bit alone.
  function automatic logic [CmdBits-1:0][CrcBits-1:0] crc_build_tbl();
    logic [CmdBits-1:0][CrcBits-1:0] tbl;
    logic [CmdBits-1:0]              cmd;
    logic [CrcBits-1:0]              crc;
    for (int i = 0; i < CmdBits; i++) begin
      cmd    = '0;
      cmd[i] = 1'b1;
      crc    = '0;
      for (int b = 0; b < CmdBytes; b++) begin
        crc = crc ^ cmd[CrcBits*(CmdBytes-1-b) +: CrcBits];
        for (int k = 0; k < CrcBits; k++) begin
          if (crc[CrcBits-1]) begin
            crc = (crc << 1) ^ CrcPoly;
          end else begin
            crc = crc << 1;
          end
        end
      end
      tbl[i] = crc;
    end
    return tbl;
  endfunction

  localparam logic [CmdBits-1:0][CrcBits-1:0] CrcBitTbl = crc_build_tbl();

endpackage

`default_nettype wire

[hw/rtl/smcf_if.sv]
// ----------------------------------------------------------------------------
// SPI master CRC-8 frame channels
// Valid/ready channels for input items and result items.
// ----------------------------------------------------------------------------
`default_nettype none

interface smcf_in_if
  import smcf_pkg::*;
();
  logic               valid;
  logic               ready;
  logic               action;
  logic [CmdBits-1:0] command;
  logic               miso_bit;

  modport source (output valid, output action, output command, output miso_bit,
                  input ready);
  modport sink   (input valid, input action, input command, input miso_bit,
                  output ready);
endinterface

interface smcf_out_if
  import smcf_pkg::*;
();
  logic                 valid;
  logic                 ready;
  logic                 mosi_bit;
  logic [FrameBits-1:0] received_word;
  logic                 frame_done;

  modport source (output valid, output mosi_bit, output received_word,
                  output frame_done, input ready);
  modport sink   (input valid, input mosi_bit, input received_word,
                  input frame_done, output ready);
endinterface

`default_nettype wire

[hw/rtl/spi_master_crc8_frame_unit.sv]
// ----------------------------------------------------------------------------
// SPI master CRC-8 frame unit
// Top level: input register, frame core and result register.
// ----------------------------------------------------------------------------
// The unit takes one item per clock cycle unless a result waits to be taken.
// A load item builds a 32-bit frame from a 24-bit command and its CRC-8;
// each shift item while a frame is loaded is one serial bit period and gives
// one result with the driven MOSI bit, and on the 32nd bit the received word
// and frame_done. An accepted item is held in the input register, and its
// result is written to the result register when the registers advance. Both
// registers advance together; when the result register is full and not taken,
// the input register holds and in_i.ready drops once it holds an item, so
// throughput is one item per cycle whenever the sink takes results every
// cycle.
`default_nettype none

module spi_master_crc8_frame_unit
  import smcf_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  smcf_in_if.sink   in_i,
  smcf_out_if.source out_o
);

  logic    in_valid_q;
  item_t   in_item_q;
  logic    out_valid_q, out_valid_d;
  result_t out_res_q;
  logic    advance;
  logic    res_valid;
  result_t res;

  assign advance    = !out_valid_q || out_o.ready;
  assign in_i.ready = !in_valid_q || advance;

  smcf_frame_core u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (in_valid_q),
    .item_i       (in_item_q),
    .advance_i    (advance),
    .res_valid_o  (res_valid),
    .res_o        (res)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    if (advance) begin
      out_valid_d = res_valid;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_i.ready) begin
        in_valid_q <= in_i.valid;
      end
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      in_item_q.action   <= in_i.action;
      in_item_q.command  <= in_i.command;
      in_item_q.miso_bit <= in_i.miso_bit;
    end
    if (advance && res_valid) begin
      out_res_q <= res;
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.mosi_bit      = out_res_q.mosi_bit;
  assign out_o.received_word = out_res_q.received_word;
  assign out_o.frame_done    = out_res_q.frame_done;

endmodule

`default_nettype wire

[hw/rtl/smcf_crc8.sv]
// ----------------------------------------------------------------------------
// SPI master CRC-8 generator
// CRC-8 (poly 0x1D, init 0, no reflection) over the three command bytes.
// ----------------------------------------------------------------------------
`default_nettype none

module smcf_crc8
  import smcf_pkg::*;
(
  input  wire logic [CmdBits-1:0] command_i,
  output logic      [CrcBits-1:0] crc_o
);

  always_comb begin
    crc_o = '0;
    for (int i = 0; i < CmdBits; i++) begin
      if (command_i[i]) begin
        crc_o = crc_o ^ CrcBitTbl[i];
      end
    end
  end

endmodule

`default_nettype wire

[hw/rtl/smcf_frame_core.sv]
// ----------------------------------------------------------------------------
// SPI master CRC-8 frame core
// Holds the transmit frame, receive word and bit position, and processes
// one registered item per advance.
// ----------------------------------------------------------------------------
`default_nettype none

module smcf_frame_core
  import smcf_pkg::*;
(
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    item_valid_i,
  input  wire item_t   item_i,
  input  wire logic    advance_i,
  output logic         res_valid_o,
  output result_t      res_o
);

  logic [FrameBits-1:0] tx_frame_q, tx_frame_d;
  logic [FrameBits-1:0] rx_shift_q, rx_shift_d;
  logic [PosBits-1:0]   bit_pos_q, bit_pos_d;
  logic                 active_q, active_d;
  logic [CrcBits-1:0]   crc;
  logic [FrameBits-1:0] rx_next;
  logic                 done;

  smcf_crc8 u_crc8 (
    .command_i (item_i.command),
    .crc_o     (crc)
  );

  always_comb begin
    rx_next            = rx_shift_q;
    rx_next[bit_pos_q] = item_i.miso_bit;
    done               = (bit_pos_q == PosLast);
  end

  always_comb begin
    tx_frame_d  = tx_frame_q;
    rx_shift_d  = rx_shift_q;
    bit_pos_d   = bit_pos_q;
    active_d    = active_q;
    res_valid_o = 1'b0;
    res_o.mosi_bit      = tx_frame_q[bit_pos_q];
    res_o.received_word = done ? rx_next : '0;
    res_o.frame_done    = done;
    if (advance_i && item_valid_i) begin
      unique case (item_i.action)
        ActLoad: begin
          tx_frame_d = {item_i.command, crc};
          rx_shift_d = '0;
          bit_pos_d  = PosFirst;
          active_d   = 1'b1;
        end
        ActShift: begin
          // A shift with no frame loaded is dropped without a result.
          if (active_q) begin
            res_valid_o = 1'b1;
            rx_shift_d  = rx_next;
            if (done) begin
              active_d  = 1'b0;
              bit_pos_d = PosFirst;
            end else begin
              bit_pos_d = bit_pos_q - 1'b1;
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tx_frame_q <= '0;
      rx_shift_q <= '0;
      bit_pos_q  <= PosFirst;
      active_q   <= 1'b0;
    end else begin
      tx_frame_q <= tx_frame_d;
      rx_shift_q <= rx_shift_d;
      bit_pos_q  <= bit_pos_d;
      active_q   <= active_d;
    end
  end

endmodule

`default_nettype wire

[hw/rtl/smcf_checker.sv]
// ----------------------------------------------------------------------------
// SPI master CRC-8 frame checker
// Port-level assertions for the frame unit, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "spi_master_crc8_frame_unit_defines.svh"

module smcf_checker
  import smcf_pkg::*;
(
  input wire logic                 clk_i,
  input wire logic                 rst_ni,
  input wire logic                 in_ready_i,
  input wire logic                 out_valid_i,
  input wire logic                 out_ready_i,
  input wire logic [FrameBits-1:0] received_word_i,
  input wire logic                 frame_done_i
);

  // A stalled result stays offered.
  `SMCF_ASSERT_NEXT(a_out_hold, out_valid_i && !out_ready_i, out_valid_i)

  // The received word is only shown on the last bit of a frame.
  `SMCF_ASSERT_SAME(a_word_only_done, out_valid_i && !frame_done_i, received_word_i == '0)

  // The input side only stalls behind a result that waits to be taken.
  `SMCF_ASSERT_SAME(a_stall_cause, !in_ready_i, out_valid_i && !out_ready_i)

endmodule

bind spi_master_crc8_frame_unit smcf_checker u_smcf_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_ready_i      (in_i.ready),
  .out_valid_i     (out_o.valid),
  .out_ready_i     (out_o.ready),
  .received_word_i (out_o.received_word),
  .frame_done_i    (out_o.frame_done)
);

`default_nettype wire
